@@ design/gcaf_pkg.sv @@
// Shared types, constants and tables of the complementary attitude filter.
`timescale 1ns / 1ps

package gcaf_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ANG_FRAC     = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int TICK_RATE    = 10000;

    localparam int RAW_W  = 16;
    localparam int RATE_W = 26;
    localparam int ANG_W  = 26;
    localparam int HDG_W  = 25;
    localparam int TICK_W = 16;
    localparam int CNT_W  = 16;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 184;

    // CORDIC datapath: inputs scaled by 2^16, gain ~1.65, plus sign headroom.
    localparam int XY_W     = 36;
    localparam int Z_W      = 34;
    localparam int STEP_W   = $clog2(CORDIC_STEPS);
    localparam int PRESCALE = 16;

    // Shared divider: magnitude dividend, doubled divisor, quotient bits.
    localparam int NUM_W = 46;
    localparam int DEN_W = 16;
    localparam int DVS_W = DEN_W + 1;
    localparam int QUO_W = 30;
    localparam int RES_W = QUO_W + 1;
    localparam int OP_W  = 33;
    localparam int COEF_W = 17;

    localparam logic [CNT_W-1:0] CALIB_RESET = 16'd1000;

    // raw * 1000 * 2^F / 2^17, exact for F = 16
    localparam int RATE_SCALE  = (1000 << FRAC_BITS) / (1 << 17);
    localparam int BLEND_OLD   = 95;
    localparam int BLEND_NEW   = 5;
    localparam int BLEND_DEN   = 100;
    localparam int HDG_OLD     = 999;
    localparam int HDG_DEN     = 1000;

    localparam logic signed [31:0] HALF_TURN = 32'sd180 <<< FRAC_BITS;
    localparam logic signed [31:0] ANG_LIM   = 32'sd360 <<< FRAC_BITS;

    typedef enum logic [1:0] {
        KIND_CALIB,
        KIND_LAST,
        KIND_RUN
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic [CNT_W-1:0]           tgt;
        logic signed [RAW_W-1:0]    gx;
        logic signed [RAW_W-1:0]    gy;
        logic signed [RAW_W-1:0]    gz;
        logic signed [RATE_W-1:0]   sx;
        logic signed [RATE_W-1:0]   sy;
        logic signed [RATE_W-1:0]   sz;
        logic signed [RAW_W-1:0]    ax;
        logic signed [RAW_W-1:0]    ay;
        logic signed [RAW_W-1:0]    az;
        logic signed [HDG_W-1:0]    hdg;
        logic [TICK_W-1:0]          ticks;
    } item_t;

    typedef struct packed {
        logic [NUM_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_OPA,
        ST_MUL,
        ST_DIV,
        ST_WAIT,
        ST_POST,
        ST_FINAL,
        ST_OUT
    } back_state_t;

    // atan(2^-i) in degrees, 2^-24 units
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(754974720);
            5'd1:    v = Z_W'(445687602);
            5'd2:    v = Z_W'(235489088);
            5'd3:    v = Z_W'(119537938);
            5'd4:    v = Z_W'(60000934);
            5'd5:    v = Z_W'(30029717);
            5'd6:    v = Z_W'(15018523);
            5'd7:    v = Z_W'(7509720);
            5'd8:    v = Z_W'(3754917);
            5'd9:    v = Z_W'(1877466);
            5'd10:   v = Z_W'(938734);
            5'd11:   v = Z_W'(469367);
            5'd12:   v = Z_W'(234684);
            5'd13:   v = Z_W'(117342);
            5'd14:   v = Z_W'(58671);
            5'd15:   v = Z_W'(29335);
            5'd16:   v = Z_W'(14668);
            5'd17:   v = Z_W'(7334);
            5'd18:   v = Z_W'(3667);
            5'd19:   v = Z_W'(1833);
            5'd20:   v = Z_W'(917);
            5'd21:   v = Z_W'(458);
            5'd22:   v = Z_W'(229);
            5'd23:   v = Z_W'(115);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ design/gcaf_front.sv @@
// Input side: accepts samples, scales the rates, tags calibration words, queues them.
`timescale 1ns / 1ps

module gcaf_front #(
    parameter int DEPTH = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr,
    input  logic [gcaf_pkg::CNT_W-1:0]     target,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gcaf_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                           q_valid,
    input  logic                           q_ready,
    output gcaf_pkg::item_t                q_item
);
    import gcaf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic signed [10:0] SCALE_C = 11'(RATE_SCALE);

    item_t             mem_reg [DEPTH];
    logic [PW-1:0]     wr_reg;
    logic [PW-1:0]     rd_reg;
    logic [FW-1:0]     fill_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              cal_reg;

    logic              push;
    logic              pop;
    logic [CNT_W-1:0]  tgt_eff;
    logic [CNT_W:0]    count_inc;
    logic              last_calib;
    item_t             new_item;

    assign tgt_eff    = (target == '0) ? CNT_W'(1) : target;
    assign count_inc  = {1'b0, count_reg} + 1'b1;
    assign last_calib = !cal_reg && (count_inc == {1'b0, tgt_eff});

    assign s_tready = (fill_reg < FW'(DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rd_reg];

    // tdata: gx, gy, gz, ax, ay, az, heading, ticks from bit 0 up
    always_comb
    begin
        new_item.gx    = s_tdata[15:0];
        new_item.gy    = s_tdata[31:16];
        new_item.gz    = s_tdata[47:32];
        new_item.ax    = s_tdata[63:48];
        new_item.ay    = s_tdata[79:64];
        new_item.az    = s_tdata[95:80];
        new_item.hdg   = s_tdata[120:96];
        new_item.ticks = s_tdata[136:121];
        new_item.sx    = RATE_W'(new_item.gx * SCALE_C);
        new_item.sy    = RATE_W'(new_item.gy * SCALE_C);
        new_item.sz    = RATE_W'(new_item.gz * SCALE_C);
        new_item.tgt   = tgt_eff;
        if (cal_reg)
        begin
            new_item.kind = KIND_RUN;
        end
        else if (last_calib)
        begin
            new_item.kind = KIND_LAST;
        end
        else
        begin
            new_item.kind = KIND_CALIB;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
            cal_reg   <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end

            if (cfg_wr)
            begin
                count_reg <= '0;
                cal_reg   <= 1'b0;
            end
            else if (push && !cal_reg)
            begin
                count_reg <= count_inc[CNT_W-1:0];
                if (last_calib)
                begin
                    cal_reg <= 1'b1;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("queue fill beyond depth");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !cal_reg |-> (count_reg < tgt_eff))
        else $error("calibration count passed its target");

    a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        push && pop |=> $stable(fill_reg))
        else $error("fill moved on simultaneous push and pop");
`endif

endmodule

@@ design/gcaf_cordic.sv @@
// Vectoring CORDIC: atan2(y, x) in degrees, one micro-rotation per cycle.
`timescale 1ns / 1ps

module gcaf_cordic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [gcaf_pkg::RAW_W-1:0]   y_in,
    input  logic signed [gcaf_pkg::RAW_W-1:0]   x_in,
    output logic                                done,
    output logic signed [gcaf_pkg::ANG_W-1:0]   angle
);
    import gcaf_pkg::*;

    localparam int RSH = ANG_FRAC - FRAC_BITS;
    localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(64'sd180 <<< ANG_FRAC);
    localparam logic signed [Z_W-1:0] RHALF  = Z_W'(1) <<< (RSH - 1);

    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   busy_reg;
    logic                   fin_reg;
    logic                   done_reg;
    logic signed [ANG_W-1:0] angle_reg;

    logic signed [XY_W-1:0] x0;
    logic signed [XY_W-1:0] y0;
    logic signed [Z_W-1:0]  z0;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  at;
    logic signed [Z_W-1:0]  zr;

    assign done  = done_reg;
    assign angle = angle_reg;

    always_comb
    begin
        x0 = XY_W'(x_in) <<< PRESCALE;
        y0 = XY_W'(y_in) <<< PRESCALE;
        z0 = '0;
        // left half plane: fold over and start from +-180
        if (x_in < 0)
        begin
            z0 = (y_in >= 0) ? Z_HALF : -Z_HALF;
            x0 = -x0;
            y0 = -y0;
        end
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = atan_entry(5'(step_reg));
        if (z_reg >= 0)
        begin
            zr = (z_reg + RHALF) >>> RSH;
        end
        else
        begin
            zr = -((-z_reg + RHALF) >>> RSH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x0;
            y_reg <= y0;
            z_reg <= z0;
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
            else if (y_reg < 0)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
        end
        if (fin_reg)
        begin
            angle_reg <= zr[ANG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

endmodule

@@ design/gcaf_div.sv @@
// Unsigned restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps

module gcaf_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  gcaf_pkg::div_req_t              req,
    output logic                            done,
    output logic [gcaf_pkg::QUO_W-1:0]      quo
);
    import gcaf_pkg::*;

    localparam int PAIRS  = QUO_W / 2;
    localparam int PAIR_W = $clog2(PAIRS);
    localparam int CMP_W  = NUM_W + 1;

    logic [NUM_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [PAIR_W-1:0] pair_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [5:0]        k_hi;
    logic [5:0]        k_lo;
    logic [CMP_W-1:0]  sh_hi;
    logic [CMP_W-1:0]  sh_lo;
    logic [CMP_W-1:0]  r_mid;
    logic [CMP_W-1:0]  r_end;
    logic              q_hi;
    logic              q_lo;

    assign done = done_reg;
    assign quo  = quo_reg;

    always_comb
    begin
        k_hi  = {pair_reg, 1'b1};
        k_lo  = {pair_reg, 1'b0};
        sh_hi = CMP_W'(dvs_reg) << k_hi;
        sh_lo = CMP_W'(dvs_reg) << k_lo;
        q_hi  = ({1'b0, rem_reg} >= sh_hi);
        r_mid = q_hi ? ({1'b0, rem_reg} - sh_hi) : {1'b0, rem_reg};
        q_lo  = (r_mid >= sh_lo);
        r_end = q_lo ? (r_mid - sh_lo) : r_mid;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= req.dividend;
            dvs_reg <= req.divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= r_end[NUM_W-1:0];
            quo_reg <= {quo_reg[QUO_W-3:0], q_hi, q_lo};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                pair_reg <= PAIR_W'(PAIRS - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                pair_reg <= pair_reg - 1'b1;
                if (pair_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ design/gcaf_back.sv @@
// Execution side: calibration sums, offsets, integration, blending, output register.
`timescale 1ns / 1ps

module gcaf_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_clear,
    input  logic                               q_valid,
    output logic                               q_ready,
    input  gcaf_pkg::item_t                    q_item,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gcaf_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [0:0]                         m_tuser
);
    import gcaf_pkg::*;

    localparam logic [2:0] JOB_FIRST    = 3'd0;
    localparam logic [2:0] JOB_AXIS_END = 3'd2;
    localparam logic [2:0] JOB_ROLL     = 3'd3;
    localparam logic [2:0] JOB_PITCH    = 3'd4;
    localparam logic [2:0] JOB_HDG      = 3'd5;

    back_state_t state_reg;
    back_state_t state_next;
    logic [2:0]  job_reg;
    logic [2:0]  job_next;

    item_t                    item_reg;
    logic signed [RATE_W-1:0] rate_reg [3];
    logic signed [RATE_W-1:0] off_reg  [3];
    logic signed [OP_W-1:0]   sum_reg  [3];
    logic signed [RES_W-1:0]  dz_reg   [3];
    logic signed [ANG_W-1:0]  roll_reg;
    logic signed [ANG_W-1:0]  pitch_reg;
    logic signed [ANG_W-1:0]  yaw_reg;
    logic signed [ANG_W-1:0]  yh_reg;

    logic signed [OP_W-1:0]   op_reg;
    logic [COEF_W-1:0]        coef_reg;
    logic signed [NUM_W-1:0]  add_reg;
    logic [DEN_W-1:0]         den_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic                     neg_reg;

    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;
    logic                     out_cal_reg;

    logic                     cor_start;
    logic                     cor_done_r;
    logic                     cor_done_p;
    logic signed [ANG_W-1:0]  acc_roll;
    logic signed [ANG_W-1:0]  acc_pitch;

    logic                     div_start;
    logic                     div_done;
    div_req_t                 div_req;
    logic [QUO_W-1:0]         div_quo;

    logic signed [RAW_W-1:0]  raw_a [3];
    logic signed [RATE_W-1:0] scl_a [3];
    logic signed [OP_W-1:0]   op_sel;
    logic [COEF_W-1:0]        coef_sel;
    logic signed [NUM_W-1:0]  add_sel;
    logic [DEN_W-1:0]         den_sel;
    logic signed [OP_W+COEF_W:0] prod;
    logic signed [NUM_W-1:0]  num_mag;
    logic signed [RES_W-1:0]  res;
    logic signed [31:0]       yaw_sum;
    logic                     out_load;
    logic                     run_item;
    logic                     cor_ready;

    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [31:0] v);
        logic signed [31:0] s;
        s = v;
        if (v > ANG_LIM)
        begin
            s = ANG_LIM;
        end
        else if (v < -ANG_LIM)
        begin
            s = -ANG_LIM;
        end
        return s[ANG_W-1:0];
    endfunction

    function automatic logic signed [ANG_W-1:0] wrap_ang(input logic signed [31:0] v);
        logic signed [31:0] w;
        w = v;
        if (v > HALF_TURN)
        begin
            w = v - (HALF_TURN <<< 1);
        end
        else if (v < -HALF_TURN)
        begin
            w = v + (HALF_TURN <<< 1);
        end
        return sat_ang(w);
    endfunction

    gcaf_cordic u_cordic_roll (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .y_in  (item_reg.ay),
        .x_in  (item_reg.az),
        .done  (cor_done_r),
        .angle (acc_roll)
    );

    gcaf_cordic u_cordic_pitch (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .y_in  (item_reg.ax),
        .x_in  (item_reg.az),
        .done  (cor_done_p),
        .angle (acc_pitch)
    );

    gcaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign run_item  = (item_reg.kind == KIND_RUN);
    assign cor_ready = cor_done_r && cor_done_p;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        raw_a[0] = item_reg.gx;
        raw_a[1] = item_reg.gy;
        raw_a[2] = item_reg.gz;
        scl_a[0] = item_reg.sx;
        scl_a[1] = item_reg.sy;
        scl_a[2] = item_reg.sz;
    end

    // operand select per job: numerator = op * coef + add, divided by den
    always_comb
    begin
        op_sel   = '0;
        coef_sel = '0;
        add_sel  = '0;
        den_sel  = DEN_W'(1);
        if (!run_item)
        begin
            op_sel   = sum_reg[job_reg[1:0]];
            coef_sel = COEF_W'(RATE_SCALE);
            den_sel  = item_reg.tgt;
        end
        else
        begin
            case (job_reg)
                JOB_ROLL:
                begin
                    op_sel   = OP_W'(roll_reg) + OP_W'(dz_reg[0]);
                    coef_sel = COEF_W'(BLEND_OLD);
                    add_sel  = NUM_W'(acc_roll) * NUM_W'(BLEND_NEW);
                    den_sel  = DEN_W'(BLEND_DEN);
                end
                JOB_PITCH:
                begin
                    op_sel   = OP_W'(pitch_reg) + OP_W'(dz_reg[1]);
                    coef_sel = COEF_W'(BLEND_OLD);
                    add_sel  = NUM_W'(acc_pitch) * NUM_W'(BLEND_NEW);
                    den_sel  = DEN_W'(BLEND_DEN);
                end
                JOB_HDG:
                begin
                    op_sel   = OP_W'(yh_reg) - OP_W'(dz_reg[2]);
                    coef_sel = COEF_W'(HDG_OLD);
                    add_sel  = NUM_W'(item_reg.hdg);
                    den_sel  = DEN_W'(HDG_DEN);
                end
                default:
                begin
                    op_sel   = OP_W'(rate_reg[job_reg[1:0]]);
                    coef_sel = COEF_W'(item_reg.ticks);
                    den_sel  = DEN_W'(TICK_RATE);
                end
            endcase
        end
    end

    always_comb
    begin
        prod    = op_reg * $signed({1'b0, coef_reg});
        num_mag = (num_reg < 0) ? -num_reg : num_reg;
        // round half away from zero: (2|n| + d) / 2d
        div_req.dividend = NUM_W'({num_mag, 1'b0}) + NUM_W'(den_reg);
        div_req.divisor  = {den_reg, 1'b0};
        res     = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        yaw_sum = 32'(yaw_reg) - 32'(dz_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        q_ready    = 1'b0;
        cor_start  = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                job_next = JOB_FIRST;
                if (run_item)
                begin
                    cor_start  = 1'b1;
                    state_next = ST_OPA;
                end
                else
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = (item_reg.kind == KIND_LAST) ? ST_OPA : ST_OUT;
            end
            ST_OPA:
            begin
                if (!(run_item && (job_reg == JOB_ROLL || job_reg == JOB_PITCH)
                      && !cor_ready))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                if (run_item && job_reg == JOB_HDG)
                begin
                    state_next = ST_FINAL;
                end
                else if (!run_item && job_reg == JOB_AXIS_END)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    job_next   = job_reg + 1'b1;
                    state_next = ST_OPA;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            item_reg <= q_item;
        end
        if (state_reg == ST_LOAD)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rate_reg[k] <= scl_a[k] - off_reg[k];
            end
        end
        if (state_reg == ST_OPA)
        begin
            op_reg   <= op_sel;
            coef_reg <= coef_sel;
            add_reg  <= add_sel;
            den_reg  <= den_sel;
        end
        if (state_reg == ST_MUL)
        begin
            num_reg <= NUM_W'(prod) + add_reg;
        end
        if (state_reg == ST_DIV)
        begin
            neg_reg <= (num_reg < 0);
        end
        if (state_reg == ST_POST && run_item && job_reg <= JOB_AXIS_END)
        begin
            dz_reg[job_reg[1:0]] <= res;
        end
        if (out_load)
        begin
            out_data_reg <= {2'b00, yh_reg, yaw_reg, pitch_reg, roll_reg,
                             rate_reg[2], rate_reg[1], rate_reg[0]};
            out_cal_reg  <= (item_reg.kind != KIND_CALIB);
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg      <= '0;
            pitch_reg     <= '0;
            yaw_reg       <= '0;
            yh_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                off_reg[k] <= '0;
                sum_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_clear)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    off_reg[k] <= '0;
                    sum_reg[k] <= '0;
                end
            end
            else
            begin
                if (state_reg == ST_SUM)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        sum_reg[k] <= sum_reg[k] + OP_W'(raw_a[k]);
                    end
                end
                if (state_reg == ST_POST)
                begin
                    if (!run_item)
                    begin
                        off_reg[job_reg[1:0]] <= res[RATE_W-1:0];
                    end
                    else
                    begin
                        case (job_reg)
                            JOB_ROLL:  roll_reg  <= sat_ang(32'(res));
                            JOB_PITCH: pitch_reg <= sat_ang(32'(res));
                            JOB_HDG:   yh_reg    <= wrap_ang(32'(res));
                            default:   ;
                        endcase
                    end
                end
                if (state_reg == ST_FINAL)
                begin
                    yaw_reg <= wrap_ang(yaw_sum);
                end
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_cal_reg;

`ifndef NO_ASSERTIONS
    a_cordic_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) && run_item && (job_reg == JOB_ROLL || job_reg == JOB_PITCH)
        |-> cor_ready)
        else $error("blend started before accelerometer angle was ready");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(roll_reg) <= ANG_LIM) && (32'(roll_reg) >= -ANG_LIM)
        && (32'(pitch_reg) <= ANG_LIM) && (32'(pitch_reg) >= -ANG_LIM))
        else $error("roll or pitch left the saturation range");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT)
        else $error("result presented without finishing a sample");
`endif

endmodule

@@ design/gyro_complementary_attitude_filter.sv @@
// Top level of the gyro complementary attitude filter.
`timescale 1ns / 1ps

// A calibration word only adds to the bias sums; the word that closes calibration also
// computes three offset quotients, and a running word six quotients that pass one after
// another through the shared 2-bit-per-cycle divider.
// The back end takes a new word only when done with the last; QUEUE_DEPTH words buffer ahead.
// Reset: asynchronous, active low; angles, offsets and calibration clear, calib_samples = 1000.
module gyro_complementary_attitude_filter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // gyro_x_raw, gyro_y_raw, gyro_z_raw, acc_x, acc_y, acc_z, heading, elapsed_ticks
    input  logic [gcaf_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // rate_x, rate_y, rate_z, roll_angle, pitch_angle, yaw_angle, yaw_to_heading
    output logic [gcaf_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // is_calibrated
    output logic [0:0]                         m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // calib_samples
    input  logic [gcaf_pkg::CNT_W-1:0]         cfg_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready
);
    import gcaf_pkg::*;

    logic [CNT_W-1:0] calib_samples_reg;
    logic             cfg_wr;
    logic             q_valid;
    logic             q_ready;
    item_t            q_item;

    // register writes always land; a write restarts calibration in both halves
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_samples_reg <= CALIB_RESET;
        end
        else if (cfg_wr)
        begin
            calib_samples_reg <= cfg_data;
        end
    end

    // front: unpack, scale rates, tag calibration words, queue
    gcaf_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .target   (calib_samples_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // back: offsets, integration, CORDIC blends, output register
    gcaf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_clear (cfg_wr),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ bench/gyro_complementary_attitude_filter_tb.sv @@
// Testbench of the gyro complementary attitude filter: random stream traffic against a predictor.
`timescale 1ns / 1ps

module gyro_complementary_attitude_filter_tb;
    import gcaf_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int LONG_HOLD      = 700;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic signed [RAW_W-1:0] gyro [3];
        logic signed [RAW_W-1:0] acc_x;
        logic signed [RAW_W-1:0] acc_y;
        logic signed [RAW_W-1:0] acc_z;
        logic signed [HDG_W-1:0] heading;
        logic [TICK_W-1:0]       ticks;
    } sample_t;

    typedef struct {
        logic [OUT_TDATA_W-1:0] fields;
        logic                   calibrated;
    } attitude_t;

    // Attitude predictor and store of pending attitude words.
    class attitude_scoreboard;
        longint calib_target;
        longint roll, pitch, yaw, yaw_hdg;
        longint offset [3];
        longint bias_sum [3];
        longint calib_cnt;
        bit     calibrated;
        attitude_t pending [$];
        int     mismatches;
        longint atan_deg [16] = '{754974720, 445687602, 235489088, 119537938, 60000934,
                                   30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                                   469367, 234684, 117342, 58671, 29335};

        function void clear_calib(longint target);
            calib_target = target;
            calib_cnt    = 0;
            calibrated   = 0;
            for (int i = 0; i < 3; i++)
            begin
                offset[i]   = 0;
                bias_sum[i] = 0;
            end
        endfunction

        function void reset_state();
            roll = 0; pitch = 0; yaw = 0; yaw_hdg = 0;
            mismatches = 0;
            clear_calib(1000);
        endfunction

        function longint rnd_div(longint num, longint den);
            if (num >= 0)
                return (num + den / 2) / den;
            return -((-num + den / 2) / den);
        endfunction

        function longint clamp(longint v, longint lim);
            if (v > lim) return lim;
            if (v < -lim) return -lim;
            return v;
        endfunction

        function longint wrap_half_turn(longint v);
            longint h;
            h = longint'(180) <<< FRAC_BITS;
            if (v > h) v -= 2 * h;
            else if (v < -h) v += 2 * h;
            return clamp(v, 2 * h);
        endfunction

        // Vectoring CORDIC, angle kept with 24 fraction bits.
        function longint tilt_angle(longint y, longint x);
            longint z, dx, dy;
            z = 0;
            x = x * 65536;
            y = y * 65536;
            if (x < 0)
            begin
                z = (y >= 0) ? (longint'(180) <<< 24) : -(longint'(180) <<< 24);
                x = -x;
                y = -y;
            end
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x += dx; y -= dy; z += atan_deg[i];
                end
                else if (y < 0)
                begin
                    x -= dx; y += dy; z -= atan_deg[i];
                end
            end
            return rnd_div(z, longint'(1) <<< (24 - FRAC_BITS));
        endfunction

        function void note_sample(sample_t s);
            longint raw [3];
            longint rate [3];
            longint t, dz, lim;
            attitude_t a;
            lim = longint'(360) <<< FRAC_BITS;
            for (int i = 0; i < 3; i++)
            begin
                raw[i]  = s.gyro[i];
                rate[i] = rnd_div(raw[i] * 1000 * (longint'(1) <<< FRAC_BITS),
                                  longint'(1) <<< 17) - offset[i];
            end
            if (calibrated)
            begin
                t     = roll + rnd_div(rate[0] * s.ticks, TICK_RATE);
                roll  = clamp(rnd_div(t * 95 + tilt_angle(s.acc_y, s.acc_z) * 5, 100), lim);
                t     = pitch + rnd_div(rate[1] * s.ticks, TICK_RATE);
                pitch = clamp(rnd_div(t * 95 + tilt_angle(s.acc_x, s.acc_z) * 5, 100), lim);
                dz    = rnd_div(rate[2] * s.ticks, TICK_RATE);
                yaw   = wrap_half_turn(yaw - dz);
                t     = rnd_div((yaw_hdg - dz) * 999 + longint'(s.heading), 1000);
                yaw_hdg = wrap_half_turn(t);
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                    bias_sum[i] += raw[i];
                calib_cnt++;
                if (calib_cnt >= ((calib_target == 0) ? 1 : calib_target))
                begin
                    for (int i = 0; i < 3; i++)
                        offset[i] = rnd_div(bias_sum[i] * 1000 * (longint'(1) <<< FRAC_BITS),
                                            calib_cnt <<< 17);
                    calibrated = 1;
                end
            end
            a.fields = {2'b00, yaw_hdg[25:0], yaw[25:0], pitch[25:0], roll[25:0],
                        rate[2][25:0], rate[1][25:0], rate[0][25:0]};
            a.calibrated = calibrated;
            pending.push_back(a);
        endfunction

        function void check_word(logic [OUT_TDATA_W-1:0] data, logic cal);
            attitude_t a;
            string names [7] = '{"rate_x", "rate_y", "rate_z", "roll_angle", "pitch_angle",
                                 "yaw_angle", "yaw_to_heading"};
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output word %h", data);
                return;
            end
            a = pending.pop_front();
            for (int f = 0; f < 7; f++)
                if (data[f*26 +: 26] !== a.fields[f*26 +: 26])
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%s: expected %0d got %0d", names[f],
                                 $signed(a.fields[f*26 +: 26]), $signed(data[f*26 +: 26]));
                end
            if (cal !== a.calibrated)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("is_calibrated: expected %0b got %0b", a.calibrated, cal);
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [0:0]              m_tuser;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [CNT_W-1:0]        cfg_data = '0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;

    attitude_scoreboard sb = new();
    bit     in_burst = 1'b0;
    int     out_count = 0;
    int     out_hold = 0;
    bit     long_hold_done = 1'b0;
    int     idle_cycles = 0;
    longint bias [3];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    gyro_complementary_attitude_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    // Output side: check accepted words, then draw the next stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                sb.check_word(m_tdata, m_tuser[0]);
                out_count++;
                if (out_count == 350 && !long_hold_done)
                begin
                    long_hold_done = 1'b1;
                    out_hold = LONG_HOLD;
                end
                else
                    out_hold = in_burst ? 0 : $urandom_range(0, 18);
                if (out_hold > 0)
                    m_tready <= 1'b0;
            end
            else if (!m_tready)
            begin
                if (out_hold > 0)
                    out_hold--;
                if (out_hold == 0)
                    m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no handshake anywhere.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_sample(sample_t s);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, s.ticks, s.heading, s.acc_z, s.acc_y, s.acc_x,
                     s.gyro[2], s.gyro[1], s.gyro[0]};
        do @(posedge clk); while (!s_tready);
        sb.note_sample(s);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_calib_count(logic [CNT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.clear_calib(v);
    endtask

    function automatic sample_t make_sample(longint gx, longint gy, longint gz, longint ax,
                                            longint ay, longint az, longint hdg, longint tk);
        sample_t s;
        s.gyro[0] = gx; s.gyro[1] = gy; s.gyro[2] = gz;
        s.acc_x = ax; s.acc_y = ay; s.acc_z = az;
        s.heading = hdg; s.ticks = tk;
        return s;
    endfunction

    // Mostly a steady bias with noise, sometimes anything the fields allow.
    function automatic sample_t random_sample();
        sample_t s;
        for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 9) < 8)
                s.gyro[i] = bias[i] + $signed($urandom_range(0, 600)) - 300;
            else
                s.gyro[i] = $urandom();
        if ($urandom_range(0, 9) < 7)
        begin
            s.acc_x = $signed($urandom_range(0, 4000)) - 2000;
            s.acc_y = $signed($urandom_range(0, 4000)) - 2000;
            s.acc_z = ($urandom_range(0, 5) == 0) ? -16384 : 16384;
        end
        else
        begin
            s.acc_x = $urandom();
            s.acc_y = ($urandom_range(0, 7) == 0) ? 0 : $urandom();
            s.acc_z = ($urandom_range(0, 7) == 0) ? 0 : $urandom();
        end
        s.heading = $signed($urandom_range(0, 23592960)) - 11796480;
        s.ticks = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 300) : $urandom();
        return s;
    endfunction

    initial
    begin
        int counts [7] = '{250, 40, 250, 250, 150, 200, 100};
        logic [CNT_W-1:0] targets [7] = '{16'd16, 16'd65535, 16'd3, 16'd1, 16'd0,
                                          16'd50, 16'd8};
        sb.reset_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Still calibrating toward the reset count.
        send_sample(make_sample(32767, -32768, 100, 0, 0, 0, 0, 65535));
        send_sample(make_sample(-32768, 32767, -100, 1, 2, 3, 0, 10));

        // Calibration closes on the first word.
        write_calib_count(16'd1);
        send_sample(make_sample(200, -150, 50, 0, 0, 16384, 0, 100));
        send_sample(make_sample(32767, 32767, 32767, 0, 0, 0, 11796480, 65535));
        send_sample(make_sample(-32768, -32768, -32768, 0, 0, 0, -11796480, 65535));
        send_sample(make_sample(0, 0, 0, -32768, 0, -32768, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, 0, -100, 11796480, 0));
        send_sample(make_sample(0, 0, 0, 32767, 32767, 32767, -11796480, 1));
        send_sample(make_sample(0, 0, 0, -32768, -32768, 1, 0, 0));
        send_sample(make_sample(32767, -32768, 32767, 0, -1, -1, 11796480, 65535));
        send_sample(make_sample(-32768, 32767, -32768, 0, 1, -1, -11796480, 65535));
        send_sample(make_sample(32767, 32767, 32767, 5, 5, 5, 11796480, 65535));
        send_sample(make_sample(32767, 32767, 32767, 5, 5, 5, 11796480, 65535));
        send_sample(make_sample(1, -1, 0, 0, 32767, 0, 0, 1));

        for (int p = 0; p < 7; p++)
        begin
            write_calib_count(targets[p]);
            for (int i = 0; i < 3; i++)
                bias[i] = $signed($urandom_range(0, 4000)) - 2000;
            for (int n = 0; n < counts[p]; n++)
            begin
                if (n % 40 == 0)
                    in_burst = ($urandom_range(0, 3) == 0);
                send_sample(random_sample());
            end
            in_burst = 1'b0;
        end

        drain();
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ gyro_complementary_attitude_filter.f @@
design/gcaf_pkg.sv
design/gcaf_front.sv
design/gcaf_cordic.sv
design/gcaf_div.sv
design/gcaf_back.sv
design/gyro_complementary_attitude_filter.sv
bench/gyro_complementary_attitude_filter_tb.sv
